[hw/rtl/sae_pkg.sv]
// shared types, constants and helpers for the stack alu core
// no dependencies; all rtl files but sae_ram refer to it by scoped names
`default_nettype none

package sae_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int DATA_W      = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int DIV_CNT_W   = $clog2(DATA_W);
  localparam int OPC_W       = 3;
  localparam int STAT_W      = 3;
  localparam int DEPTH_W     = 7;

  localparam logic [OPC_W-1:0] OP_PUSH = 3'd0;
  localparam logic [OPC_W-1:0] OP_ADD  = 3'd1;
  localparam logic [OPC_W-1:0] OP_SUB  = 3'd2;
  localparam logic [OPC_W-1:0] OP_MUL  = 3'd3;
  localparam logic [OPC_W-1:0] OP_DIV  = 3'd4;
  localparam logic [OPC_W-1:0] OP_MOD  = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY   = 3'd1;
  localparam logic [STAT_W-1:0] ST_DIVZERO = 3'd2;
  localparam logic [STAT_W-1:0] ST_UNKNOWN = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL    = 3'd4;

  typedef struct packed {
    logic [OPC_W-1:0]         opcode;
    logic signed [DATA_W-1:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] top_value;
    logic [STAT_W-1:0]        status;
    logic [DEPTH_W-1:0]       depth;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_OPER,
    S_DIV,
    S_REFILL
  } state_t;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quotient;
    logic [DATA_W-1:0] remainder;
  } div_rsp_t;

  function automatic logic [DATA_W-1:0] magnitude(input logic [DATA_W-1:0] v);
    magnitude = v[DATA_W-1] ? (DATA_W'(0) - v) : v;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/stack_alu_with_errors_core.sv]
// top level of the stack alu core: control sequencer, stack ram and divider
// depends on sae_pkg, sae_ram and sae_div
`default_nettype none

// Forth-style data stack with an integer alu. The stack lives in a synchronous
// ram, and the top element is also held in a register. Push, unknown opcodes
// and underflow finish in the cycle they are accepted; add, subtract and
// multiply pass through S_OPER (one stack ram read of the next element);
// divide by zero ends in S_OPER, or in S_REFILL when a new top must be read;
// divide and modulo wait in S_DIV for the divider, making one quotient bit
// per cycle. One item is worked on at a time. The result sits in an output
// register, and a new item is taken as soon as that register is free or its
// transfer happens in the same cycle. No clearing pass follows reset.

module stack_alu_with_errors_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire sae_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output sae_pkg::out_item_t      out_data
);

  sae_pkg::state_t                 state_r, state_nxt;
  logic [sae_pkg::CNT_W-1:0]       count_r, count_nxt;
  logic [sae_pkg::DATA_W-1:0]      top_r, top_nxt;
  logic [sae_pkg::OPC_W-1:0]       op_r;
  logic                            aneg_r, bneg_r;
  logic                            out_valid_r, out_valid_nxt;
  sae_pkg::out_item_t              out_data_r, out_data_nxt;

  logic                            accept;
  logic                            out_free;
  logic                            load;
  logic [sae_pkg::STAT_W-1:0]      status_v;
  logic [sae_pkg::DATA_W-1:0]      result_v;
  logic [sae_pkg::CNT_W-1:0]       cnt_m1, cnt_m2, cnt_m3;

  logic                            ram_we;
  logic [sae_pkg::ADDR_W-1:0]      ram_waddr, ram_raddr;
  logic [sae_pkg::DATA_W-1:0]      ram_wdata, ram_rdata;

  sae_pkg::div_req_t               div_req;
  sae_pkg::div_rsp_t               div_rsp;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != sae_pkg::S_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;

  assign cnt_m1 = count_r - sae_pkg::CNT_W'(1);
  assign cnt_m2 = count_r - sae_pkg::CNT_W'(2);
  assign cnt_m3 = count_r - sae_pkg::CNT_W'(3);

  sae_ram #(
    .WIDTH (sae_pkg::DATA_W),
    .DEPTH (sae_pkg::STACK_DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  sae_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sae_pkg::S_IDLE: begin
        if (accept && in_data.opcode >= sae_pkg::OP_ADD &&
            in_data.opcode <= sae_pkg::OP_MOD && count_r >= sae_pkg::CNT_W'(2)) begin
          state_nxt = sae_pkg::S_OPER;
        end
      end
      sae_pkg::S_OPER: begin
        if (op_r == sae_pkg::OP_DIV || op_r == sae_pkg::OP_MOD) begin
          if (top_r == '0) begin
            state_nxt = (count_r >= sae_pkg::CNT_W'(3)) ? sae_pkg::S_REFILL
                                                        : sae_pkg::S_IDLE;
          end else begin
            state_nxt = sae_pkg::S_DIV;
          end
        end else begin
          state_nxt = sae_pkg::S_IDLE;
        end
      end
      sae_pkg::S_DIV: begin
        if (div_rsp.done) begin
          state_nxt = sae_pkg::S_IDLE;
        end
      end
      sae_pkg::S_REFILL: begin
        state_nxt = sae_pkg::S_IDLE;
      end
      default: begin
        state_nxt = sae_pkg::S_IDLE;
      end
    endcase
  end

  // datapath and outputs
  always_comb begin
    count_nxt        = count_r;
    top_nxt          = top_r;
    ram_we           = 1'b0;
    ram_waddr        = cnt_m2[sae_pkg::ADDR_W-1:0];
    ram_wdata        = top_r;
    ram_raddr        = cnt_m2[sae_pkg::ADDR_W-1:0];
    load             = 1'b0;
    status_v         = sae_pkg::ST_OK;
    result_v         = '0;
    div_req.start    = 1'b0;
    div_req.dividend = sae_pkg::magnitude(ram_rdata);
    div_req.divisor  = sae_pkg::magnitude(top_r);
    case (state_r)
      sae_pkg::S_IDLE: begin
        if (accept) begin
          case (in_data.opcode)
            sae_pkg::OP_PUSH: begin
              load = 1'b1;
              if (count_r == sae_pkg::CNT_W'(sae_pkg::STACK_DEPTH)) begin
                status_v = sae_pkg::ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = count_r[sae_pkg::ADDR_W-1:0];
                ram_wdata = in_data.push_value;
                top_nxt   = in_data.push_value;
                count_nxt = count_r + sae_pkg::CNT_W'(1);
              end
            end
            sae_pkg::OP_ADD, sae_pkg::OP_SUB, sae_pkg::OP_MUL,
            sae_pkg::OP_DIV, sae_pkg::OP_MOD: begin
              if (count_r == '0) begin
                load     = 1'b1;
                status_v = sae_pkg::ST_EMPTY;
              end else if (count_r == sae_pkg::CNT_W'(1)) begin
                load      = 1'b1;
                status_v  = sae_pkg::ST_EMPTY;
                count_nxt = '0;
                top_nxt   = '0;
              end
            end
            default: begin
              load     = 1'b1;
              status_v = sae_pkg::ST_UNKNOWN;
            end
          endcase
        end
      end
      sae_pkg::S_OPER: begin
        case (op_r)
          sae_pkg::OP_ADD, sae_pkg::OP_SUB, sae_pkg::OP_MUL: begin
            if (op_r == sae_pkg::OP_ADD) begin
              result_v = ram_rdata + top_r;
            end else if (op_r == sae_pkg::OP_SUB) begin
              result_v = ram_rdata - top_r;
            end else begin
              result_v = sae_pkg::DATA_W'(ram_rdata * top_r);
            end
            ram_we    = 1'b1;
            ram_wdata = result_v;
            top_nxt   = result_v;
            count_nxt = cnt_m1;
            load      = 1'b1;
          end
          default: begin
            if (top_r == '0) begin
              count_nxt = cnt_m2;
              status_v  = sae_pkg::ST_DIVZERO;
              if (count_r >= sae_pkg::CNT_W'(3)) begin
                ram_raddr = cnt_m3[sae_pkg::ADDR_W-1:0];
              end else begin
                top_nxt = '0;
                load    = 1'b1;
              end
            end else begin
              div_req.start = 1'b1;
            end
          end
        endcase
      end
      sae_pkg::S_DIV: begin
        if (div_rsp.done) begin
          if (op_r == sae_pkg::OP_DIV) begin
            result_v = (aneg_r != bneg_r) ? (sae_pkg::DATA_W'(0) - div_rsp.quotient)
                                          : div_rsp.quotient;
          end else begin
            result_v = bneg_r ? (sae_pkg::DATA_W'(0) - div_rsp.remainder)
                              : div_rsp.remainder;
          end
          ram_we    = 1'b1;
          ram_wdata = result_v;
          top_nxt   = result_v;
          count_nxt = cnt_m1;
          load      = 1'b1;
        end
      end
      sae_pkg::S_REFILL: begin
        top_nxt  = ram_rdata;
        status_v = sae_pkg::ST_DIVZERO;
        load     = 1'b1;
      end
      default: begin
        load = 1'b0;
      end
    endcase
    out_valid_nxt          = load || (out_valid_r && out_stall);
    out_data_nxt           = out_data_r;
    if (load) begin
      out_data_nxt.top_value = top_nxt;
      out_data_nxt.status    = status_v;
      out_data_nxt.depth     = sae_pkg::DEPTH_W'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sae_pkg::S_IDLE;
      count_r     <= '0;
      top_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      top_r       <= top_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (accept) begin
      op_r <= in_data.opcode;
    end
    if (state_r == sae_pkg::S_OPER) begin
      aneg_r <= top_r[sae_pkg::DATA_W-1];
      bneg_r <= ram_rdata[sae_pkg::DATA_W-1];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

[hw/rtl/sae_ram.sv]
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
`default_nettype none

module sae_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hw/rtl/sae_div.sv]
// iterative unsigned restoring divider, one quotient bit per cycle
// depends on sae_pkg for widths and the request/response structs
`default_nettype none

module sae_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire sae_pkg::div_req_t req,
  output sae_pkg::div_rsp_t      rsp
);

  logic [sae_pkg::DATA_W-1:0]    rem_r;
  logic [sae_pkg::DATA_W-1:0]    quo_r;
  logic [sae_pkg::DATA_W-1:0]    dvs_r;
  logic [sae_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                          busy_r;
  logic                          done_r;
  logic [sae_pkg::DATA_W:0]      shifted;
  logic [sae_pkg::DATA_W:0]      diff;

  assign shifted = {rem_r, quo_r[sae_pkg::DATA_W-1]};
  assign diff    = shifted - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == sae_pkg::DIV_CNT_W'(sae_pkg::DATA_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + sae_pkg::DIV_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.dividend;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= diff[sae_pkg::DATA_W] ? shifted[sae_pkg::DATA_W-1:0]
                                     : diff[sae_pkg::DATA_W-1:0];
      quo_r <= {quo_r[sae_pkg::DATA_W-2:0], ~diff[sae_pkg::DATA_W]};
    end
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

endmodule

`default_nettype wire

[hw/rtl/sae_chk.sv]
// port-level checker for the stack alu core, attached by bind
// depends on sae_pkg and on the ports of stack_alu_with_errors_core
`default_nettype none

module sae_chk (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire sae_pkg::out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("stalled result changed");

  a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.depth == '0 |-> out_data.top_value == '0)
    else $error("empty stack with nonzero top");

  a_full_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == sae_pkg::ST_FULL |->
      out_data.depth == sae_pkg::DEPTH_W'(sae_pkg::STACK_DEPTH))
    else $error("stack full reported below full depth");

  a_depth_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && sae_pkg::STACK_DEPTH < 128 |->
      out_data.depth <= sae_pkg::DEPTH_W'(sae_pkg::STACK_DEPTH))
    else $error("depth above stack size");

endmodule

bind stack_alu_with_errors_core sae_chk u_sae_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
